@@ design/robin_hood_hash_table_unit_assert.svh @@
// assertion macros for the robin hood hash table unit
`ifndef ROBIN_HOOD_HASH_TABLE_UNIT_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_UNIT_ASSERT_SVH

// consequent checked in the same cycle
`define RHHT_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rhht assertion failed");

// consequent checked in the cycle after the antecedent
`define RHHT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rhht assertion failed");

`endif

@@ design/rhht_pkg.sv @@
// types, constants and codes of the robin hood hash table unit
package rhht_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = IDX_W + 1;
   localparam int HASH_W     = 64;
   localparam int KEY_W      = 32;
   localparam int VAL_W      = 32;
   localparam int MOD_W      = 11;
   localparam int MAXE_W     = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = MOD_W;
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = HASH_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [MOD_W-1:0]  MOD_RESET  = MOD_W'(1021);
   localparam logic [MAXE_W-1:0] MAXE_RESET = MAXE_W'(870);

   localparam logic [CSR_IDX_W-1:0] CSR_HOME_MODULUS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES  = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      OP_GET    = 2'd0,
      OP_PUT    = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_HIT       = 2'd0,
      STAT_INSERTED  = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_HOME,
      S_FRD,
      S_FCHK,
      S_FDIST,
      S_INS_RD,
      S_INS_CHK,
      S_INS_DIST,
      S_DEL_RD,
      S_DEL_CHK,
      S_DEL_DIST,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } slot_row_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_row_type     row;
   } slot_wr_type;

endpackage

@@ design/rhht_if.sv @@
// request and response channel interfaces of the hash table unit
interface rhht_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [rhht_pkg::HASH_W-1:0] key_hash;
   logic [rhht_pkg::KEY_W-1:0]  key;
   logic [rhht_pkg::VAL_W-1:0]  value;

   modport source (output valid, output opcode, output key_hash, output key, output value,
                   input ready);
   modport sink (input valid, input opcode, input key_hash, input key, input value,
                 output ready);
endinterface

interface rhht_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic [rhht_pkg::VAL_W-1:0] found_value;
   logic [rhht_pkg::CNT_W-1:0] entry_count;

   modport source (output valid, output status, output found_value, output entry_count,
                   input ready);
   modport sink (input valid, input status, input found_value, input entry_count,
                 output ready);
endinterface

@@ design/rhht_mod_unit.sv @@
// iterative remainder unit: 64-bit hash modulo an 11-bit modulus, four bits a cycle
module rhht_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rhht_pkg::HASH_W-1:0] dividend,
   input  logic [rhht_pkg::MOD_W-1:0]  divisor,
   output logic                        done,
   output logic [rhht_pkg::IDX_W-1:0]  remainder
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [rhht_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic [rhht_pkg::MOD_W-1:0]     rem_ff;
   logic [rhht_pkg::MOD_W-1:0]     rem_in;
   logic [rhht_pkg::HASH_W-1:0]    dvd_ff;
   logic [rhht_pkg::HASH_W-1:0]    dvd_in;
   logic [rhht_pkg::MOD_W-1:0]     div_ff;

   always_comb begin
      logic [rhht_pkg::MOD_W:0] t;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      for (int i = 0; i < rhht_pkg::DIV_BITS; i++) begin
         t = {rem_in, dvd_in[rhht_pkg::HASH_W-1]};
         dvd_in = {dvd_in[rhht_pkg::HASH_W-2:0], 1'b0};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         rem_in = t[rhht_pkg::MOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + rhht_pkg::DIV_CNT_W'(1);
            if (cnt_ff == rhht_pkg::DIV_CNT_W'(rhht_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // a zero modulus acts as one
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         div_ff <= (divisor == '0) ? rhht_pkg::MOD_W'(1) : divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[rhht_pkg::IDX_W-1:0];

endmodule

@@ design/rhht_slot_store.sv @@
// slot memory: one write and one registered read per cycle
module rhht_slot_store (
   input  logic                         clock,
   input  rhht_pkg::slot_wr_type        wr,
   input  logic                         rd_en,
   input  logic [rhht_pkg::IDX_W-1:0]   rd_addr,
   output rhht_pkg::slot_row_type       rd_row
);

   rhht_pkg::slot_row_type mem [rhht_pkg::TABLE_SIZE];
   rhht_pkg::slot_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.row;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   assign rd_row = rd_row_ff;

endmodule

@@ design/robin_hood_hash_table_unit.sv @@
// robin hood hash table unit: sequencer over a slot memory and a shared remainder unit
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      opcode, key_hash, key, value
//   rsp      out  valid/ready      status, found_value, entry_count
//   csr      in   csr_we           csr_index, csr_wdata
//
// get/put/delete: the remainder unit first works out the home slot, then each probed slot is
// read and checked, and its resident's home is worked out by the remainder unit when needed.
// clear writes every slot, one slot write per cycle through the memory port.
// after reset the same sweep runs with req ready low.
// one request at a time; a waiting response does not block the next request until it finishes.
`include "robin_hood_hash_table_unit_assert.svh"

module robin_hood_hash_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   rhht_req_if.sink                          req_chan,
   rhht_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [rhht_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rhht_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rhht_pkg::state_type            state_ff, state_in;
   rhht_pkg::op_type               op_ff, op_in;
   logic [rhht_pkg::HASH_W-1:0]    hash_ff, hash_in;
   logic [rhht_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [rhht_pkg::VAL_W-1:0]     val_ff, val_in;
   logic [rhht_pkg::IDX_W-1:0]     home_ff, home_in;
   logic [rhht_pkg::IDX_W-1:0]     idx_ff, idx_in;
   logic [rhht_pkg::IDX_W-1:0]     hole_ff, hole_in;
   logic [rhht_pkg::CNT_W-1:0]     dist_ff, dist_in;
   logic [rhht_pkg::CNT_W-1:0]     step_ff, step_in;
   logic [rhht_pkg::CNT_W-1:0]     live_ff, live_in;
   rhht_pkg::slot_row_type         cur_row_ff, cur_row_in;
   rhht_pkg::status_type           status_ff, status_in;
   logic [rhht_pkg::VAL_W-1:0]     found_ff, found_in;
   logic                           sweep_rsp_ff, sweep_rsp_in;
   logic [rhht_pkg::MOD_W-1:0]     mod_ff;
   logic [rhht_pkg::MAXE_W-1:0]    max_ff;

   logic                           rsp_valid_ff;
   rhht_pkg::status_type           rsp_status_ff;
   logic [rhht_pkg::VAL_W-1:0]     rsp_found_ff;
   logic [rhht_pkg::CNT_W-1:0]     rsp_count_ff;
   logic                           rsp_load;

   logic                           div_start;
   logic [rhht_pkg::HASH_W-1:0]    div_dividend;
   logic                           div_done;
   logic [rhht_pkg::IDX_W-1:0]     div_rem;

   rhht_pkg::slot_wr_type          store_wr;
   logic                           rd_en;
   rhht_pkg::slot_row_type         rd_row;

   logic                           find_hit, find_miss, find_adv, ins_adv, del_fin;
   logic [rhht_pkg::IDX_W-1:0]     idx_nxt, dist_cur, home_cur;
   logic [rhht_pkg::CNT_W-1:0]     ins_d;
   logic                           key_match;

   logic                           div_wait_state;
   logic                           rsp_is_full;

   rhht_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (mod_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   rhht_slot_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_row  (rd_row)
   );

   assign idx_nxt   = idx_ff + rhht_pkg::IDX_W'(1);
   assign dist_cur  = idx_ff - div_rem;
   assign home_cur  = (state_ff == rhht_pkg::S_HOME) ? div_rem : home_ff;
   assign key_match = (rd_row.hash == hash_ff) && (rd_row.key == key_ff);

   assign req_chan.ready = (state_ff == rhht_pkg::S_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hash_in      = hash_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      home_in      = home_ff;
      idx_in       = idx_ff;
      hole_in      = hole_ff;
      dist_in      = dist_ff;
      step_in      = step_ff;
      live_in      = live_ff;
      cur_row_in   = cur_row_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      sweep_rsp_in = sweep_rsp_ff;
      div_start    = 1'b0;
      div_dividend = rd_row.hash;
      store_wr     = '0;
      rd_en        = 1'b0;
      rsp_load     = 1'b0;
      find_hit     = 1'b0;
      find_miss    = 1'b0;
      find_adv     = 1'b0;
      ins_adv      = 1'b0;
      del_fin      = 1'b0;
      ins_d        = dist_ff;

      unique case (state_ff)
         rhht_pkg::S_SWEEP: begin
            store_wr.en   = 1'b1;
            store_wr.addr = step_ff[rhht_pkg::IDX_W-1:0];
            step_in       = step_ff + rhht_pkg::CNT_W'(1);
            if (step_ff == rhht_pkg::CNT_W'(rhht_pkg::TABLE_SIZE - 1)) begin
               step_in      = '0;
               sweep_rsp_in = 1'b0;
               if (sweep_rsp_ff) begin
                  live_in   = '0;
                  status_in = rhht_pkg::STAT_HIT;
                  found_in  = '0;
                  state_in  = rhht_pkg::S_DONE;
               end else begin
                  state_in = rhht_pkg::S_IDLE;
               end
            end
         end
         rhht_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               op_in   = rhht_pkg::op_type'(req_chan.opcode);
               hash_in = req_chan.key_hash;
               key_in  = req_chan.key;
               val_in  = req_chan.value;
               if (rhht_pkg::op_type'(req_chan.opcode) == rhht_pkg::OP_CLEAR) begin
                  step_in      = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = rhht_pkg::S_SWEEP;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = req_chan.key_hash;
                  state_in     = rhht_pkg::S_HOME;
               end
            end
         end
         rhht_pkg::S_HOME: begin
            if (div_done) begin
               home_in = div_rem;
               idx_in  = div_rem;
               dist_in = '0;
               if (live_ff == '0) begin
                  find_miss = 1'b1;
               end else begin
                  state_in = rhht_pkg::S_FRD;
               end
            end
         end
         rhht_pkg::S_FRD: begin
            rd_en    = 1'b1;
            state_in = rhht_pkg::S_FCHK;
         end
         rhht_pkg::S_FCHK: begin
            // a matching hash sits at the same distance as the search, so no divide
            if (!rd_row.valid) begin
               find_miss = 1'b1;
            end else if (key_match) begin
               find_hit = 1'b1;
            end else if (dist_ff == '0) begin
               find_adv = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = rhht_pkg::S_FDIST;
            end
         end
         rhht_pkg::S_FDIST: begin
            if (div_done) begin
               if ({1'b0, dist_cur} < dist_ff) begin
                  find_miss = 1'b1;
               end else begin
                  find_adv = 1'b1;
               end
            end
         end
         rhht_pkg::S_INS_RD: begin
            rd_en    = 1'b1;
            state_in = rhht_pkg::S_INS_CHK;
         end
         rhht_pkg::S_INS_CHK: begin
            if (!rd_row.valid) begin
               store_wr.en   = 1'b1;
               store_wr.addr = idx_ff;
               store_wr.row  = cur_row_ff;
               live_in       = live_ff + rhht_pkg::CNT_W'(1);
               status_in     = rhht_pkg::STAT_INSERTED;
               found_in      = '0;
               state_in      = rhht_pkg::S_DONE;
            end else if (dist_ff == '0) begin
               ins_adv = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = rhht_pkg::S_INS_DIST;
            end
         end
         rhht_pkg::S_INS_DIST: begin
            if (div_done) begin
               // the resident is richer: it gives up the slot and is carried on
               if ({1'b0, dist_cur} < dist_ff) begin
                  store_wr.en   = 1'b1;
                  store_wr.addr = idx_ff;
                  store_wr.row  = cur_row_ff;
                  cur_row_in    = rd_row;
                  ins_d         = {1'b0, dist_cur};
               end
               ins_adv = 1'b1;
            end
         end
         rhht_pkg::S_DEL_RD: begin
            if (step_ff == rhht_pkg::CNT_W'(rhht_pkg::TABLE_SIZE - 1)) begin
               del_fin = 1'b1;
            end else begin
               rd_en    = 1'b1;
               state_in = rhht_pkg::S_DEL_CHK;
            end
         end
         rhht_pkg::S_DEL_CHK: begin
            if (!rd_row.valid) begin
               del_fin = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = rhht_pkg::S_DEL_DIST;
            end
         end
         rhht_pkg::S_DEL_DIST: begin
            if (div_done) begin
               if (div_rem == idx_ff) begin
                  del_fin = 1'b1;
               end else begin
                  // pull the entry back into the hole
                  store_wr.en   = 1'b1;
                  store_wr.addr = hole_ff;
                  store_wr.row  = rd_row;
                  hole_in       = idx_ff;
                  idx_in        = idx_nxt;
                  step_in       = step_ff + rhht_pkg::CNT_W'(1);
                  state_in      = rhht_pkg::S_DEL_RD;
               end
            end
         end
         rhht_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = rhht_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rhht_pkg::S_IDLE;
         end
      endcase

      if (find_adv) begin
         idx_in  = idx_nxt;
         dist_in = dist_ff + rhht_pkg::CNT_W'(1);
         if (dist_ff == rhht_pkg::CNT_W'(rhht_pkg::TABLE_SIZE - 1)) begin
            find_miss = 1'b1;
         end else begin
            state_in = rhht_pkg::S_FRD;
         end
      end

      if (find_hit) begin
         status_in = rhht_pkg::STAT_HIT;
         found_in  = '0;
         state_in  = rhht_pkg::S_DONE;
         case (op_ff)
            rhht_pkg::OP_GET: begin
               found_in = rd_row.value;
            end
            rhht_pkg::OP_PUT: begin
               store_wr.en        = 1'b1;
               store_wr.addr      = idx_ff;
               store_wr.row       = rd_row;
               store_wr.row.value = val_ff;
            end
            rhht_pkg::OP_DELETE: begin
               found_in = rd_row.value;
               hole_in  = idx_ff;
               idx_in   = idx_nxt;
               step_in  = '0;
               state_in = rhht_pkg::S_DEL_RD;
            end
            default: begin
            end
         endcase
      end

      if (find_miss) begin
         found_in = '0;
         state_in = rhht_pkg::S_DONE;
         if (op_ff != rhht_pkg::OP_PUT) begin
            status_in = rhht_pkg::STAT_NOT_FOUND;
         end else if (live_ff >= {1'b0, max_ff} ||
                      live_ff >= rhht_pkg::CNT_W'(rhht_pkg::TABLE_SIZE)) begin
            status_in = rhht_pkg::STAT_FULL;
         end else begin
            idx_in     = home_cur;
            dist_in    = '0;
            step_in    = '0;
            cur_row_in = {1'b1, hash_ff, key_ff, val_ff};
            state_in   = rhht_pkg::S_INS_RD;
         end
      end

      if (ins_adv) begin
         idx_in  = idx_nxt;
         dist_in = ins_d + rhht_pkg::CNT_W'(1);
         step_in = step_ff + rhht_pkg::CNT_W'(1);
         if (step_ff == rhht_pkg::CNT_W'(rhht_pkg::TABLE_SIZE - 1)) begin
            live_in   = live_ff + rhht_pkg::CNT_W'(1);
            status_in = rhht_pkg::STAT_INSERTED;
            found_in  = '0;
            state_in  = rhht_pkg::S_DONE;
         end else begin
            state_in = rhht_pkg::S_INS_RD;
         end
      end

      if (del_fin) begin
         store_wr.en   = 1'b1;
         store_wr.addr = hole_ff;
         store_wr.row  = '0;
         live_in       = live_ff - rhht_pkg::CNT_W'(1);
         status_in     = rhht_pkg::STAT_HIT;
         state_in      = rhht_pkg::S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhht_pkg::S_SWEEP;
         step_ff      <= '0;
         live_ff      <= '0;
         sweep_rsp_ff <= 1'b0;
         op_ff        <= rhht_pkg::OP_GET;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         live_ff      <= live_in;
         sweep_rsp_ff <= sweep_rsp_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff    <= hash_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      home_ff    <= home_in;
      idx_ff     <= idx_in;
      hole_ff    <= hole_in;
      dist_ff    <= dist_in;
      cur_row_ff <= cur_row_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= rhht_pkg::MOD_RESET;
         max_ff <= rhht_pkg::MAXE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rhht_pkg::CSR_HOME_MODULUS: mod_ff <= csr_wdata;
            rhht_pkg::CSR_MAX_ENTRIES:  max_ff <= csr_wdata[rhht_pkg::MAXE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
         rsp_count_ff  <= live_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_value = rsp_found_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

   // states that wait on the remainder unit
   assign div_wait_state = (state_ff == rhht_pkg::S_HOME) ||
                           (state_ff == rhht_pkg::S_FDIST) ||
                           (state_ff == rhht_pkg::S_INS_DIST) ||
                           (state_ff == rhht_pkg::S_DEL_DIST);
   assign rsp_is_full    = rsp_chan.valid && (rsp_chan.status == rhht_pkg::STAT_FULL);

   `RHHT_ASSERT_SAME(a_live_bound, 1'b1, live_ff <= rhht_pkg::CNT_W'(rhht_pkg::TABLE_SIZE))
   `RHHT_ASSERT_NEXT(a_div_wait, div_start, div_wait_state)
   `RHHT_ASSERT_SAME(a_no_write_idle, store_wr.en, state_ff != rhht_pkg::S_IDLE)
   `RHHT_ASSERT_SAME(a_full_zero, rsp_is_full, rsp_chan.found_value == '0)

endmodule
